FILE: rtl/pcc_pkg.sv
// Shared types and constants of the palette color cycler.
`default_nettype none

package pcc_pkg;

	localparam int COMP_W      = 6;
	localparam int INDEX_W     = 8;
	localparam int SIZE_W      = INDEX_W + 1;
	localparam int WEIGHT_W    = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int OUTQ_DEPTH  = 8;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_REWIND = 2'd3
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_INDEX       = 2'd0,
		REG_LAST_INDEX        = 2'd1,
		REG_CYCLE_DELAY       = 2'd2,
		REG_REVERSE_DIRECTION = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic [INDEX_W-1:0] first;
		logic [INDEX_W-1:0] last;
		logic               ranged;
		logic [SIZE_W-1:0]  size;
		logic               blend_en;
	} range_t;

	typedef struct packed {
		logic                busy;
		logic [INDEX_W-1:0]  offset_now;
		logic [INDEX_W-1:0]  offset_next;
		logic [WEIGHT_W-1:0] weight;
	} rot_t;

endpackage

`default_nettype wire

FILE: rtl/pcc_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module pcc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pcc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module pcc_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  busy,
	output logic      [NUM_W-1:0] quotient,
	output logic      [DEN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("divider idle after start");

endmodule

`default_nettype wire

FILE: rtl/pcc_rot.sv
// Configuration, rotation offset, tick count and derived offset and blend weight.
`default_nettype none

module pcc_rot
	import pcc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   tick,
	input  wire logic                   rewind,
	output range_t                      rng,
	output rot_t                        rot
);

	logic [INDEX_W-1:0]  first_q;
	logic [INDEX_W-1:0]  last_q;
	logic [INDEX_W-1:0]  delay_q;
	logic                reverse_q;
	logic [INDEX_W-1:0]  offset_q;
	logic [INDEX_W-1:0]  tick_q;
	logic                go_q;

	logic [INDEX_W-1:0]  eff_delay;
	logic [SIZE_W-1:0]   tick_inc;
	logic [SIZE_W-1:0]   size_m1;
	logic [SIZE_W-1:0]   off_inc;
	logic [SIZE_W-1:0]   mod_den;
	logic [SIZE_W-1:0]   mod_rem;
	logic [WEIGHT_W-1:0] wt_quo;
	logic                mod_busy;
	logic                wt_busy;
	logic [INDEX_W-1:0]  o1;

	always_comb begin
		eff_delay    = (delay_q == '0) ? INDEX_W'(1) : delay_q;
		rng.first    = first_q;
		rng.last     = last_q;
		rng.ranged   = last_q >= first_q;
		rng.size     = rng.ranged ? ({1'b0, last_q} - {1'b0, first_q} + SIZE_W'(1)) : '0;
		rng.blend_en = rng.size > SIZE_W'(2);
		mod_den      = rng.ranged ? rng.size : SIZE_W'(1);
		size_m1      = rng.size - SIZE_W'(1);
		o1           = mod_rem[INDEX_W-1:0];
		off_inc      = {1'b0, o1} + SIZE_W'(1);
		tick_inc     = {1'b0, tick_q} + SIZE_W'(1);
		rot.busy     = go_q | mod_busy | wt_busy;
		rot.offset_now = o1;
		if (reverse_q) begin
			rot.offset_next = (o1 == '0) ? size_m1[INDEX_W-1:0] : o1 - 1'b1;
		end else begin
			rot.offset_next = (off_inc == rng.size) ? '0 : off_inc[INDEX_W-1:0];
		end
		rot.weight = wt_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			last_q    <= '0;
			delay_q   <= INDEX_W'(1);
			reverse_q <= 1'b0;
			offset_q  <= '0;
			tick_q    <= '0;
			go_q      <= 1'b1;
		end else begin
			go_q <= cfg_write | tick | rewind;
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FIRST_INDEX:       first_q   <= cfg_data[INDEX_W-1:0];
					REG_LAST_INDEX:        last_q    <= cfg_data[INDEX_W-1:0];
					REG_CYCLE_DELAY:       delay_q   <= cfg_data[INDEX_W-1:0];
					REG_REVERSE_DIRECTION: reverse_q <= cfg_data[0];
				endcase
			end
			if (rewind) begin
				offset_q <= '0;
				tick_q   <= '0;
			end else if (tick) begin
				if (tick_inc < {1'b0, eff_delay}) begin
					tick_q <= tick_inc[INDEX_W-1:0];
				end else begin
					tick_q <= '0;
					if (rng.ranged) begin
						offset_q <= rot.offset_next;
					end
				end
			end
		end
	end

	pcc_div #(
		.NUM_W(INDEX_W),
		.DEN_W(SIZE_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend (offset_q),
		.divisor  (mod_den),
		.busy     (mod_busy),
		.quotient (),
		.remainder(mod_rem)
	);

	pcc_div #(
		.NUM_W(WEIGHT_W),
		.DEN_W(INDEX_W)
	) u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend ({tick_q, 8'h00}),
		.divisor  (eff_delay),
		.busy     (wt_busy),
		.quotient (wt_quo),
		.remainder()
	);

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tick || rewind || cfg_write) |=> rot.busy)
		else $error("state change without recompute");

	a_offset_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(!rot.busy && rng.ranged) |-> ({1'b0, rot.offset_now} < rng.size))
		else $error("offset not reduced into range");

endmodule

`default_nettype wire

FILE: rtl/pcc_outq.sv
// Output queue of finished colors.
`default_nettype none

module pcc_outq
	import pcc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire color_t push_data,
	input  wire logic   pop,
	output logic        valid,
	output color_t      head
);

	localparam int PW = $clog2(OUTQ_DEPTH);

	color_t        slot_q [OUTQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign valid = count_q != '0;
	assign head  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/palette_color_cycler.sv
// Palette color cycler with blended rotation, top level.
//
// Loads and color reads are taken one per cycle while the input is not stalled; a read's
// color passes the capture stage, the RAM read and the blend stage to an eight-item
// output queue that takes new items while the output is stalled. A tick, a rewind or a
// register write starts a recompute of the reduced rotation offset and the blend weight
// by a 16-step divider; the input stalls while it runs, and for the recompute that runs
// after reset. Colors live in one RAM with two read ports that fetch both blend
// endpoints in the same cycle.
`default_nettype none

module palette_color_cycler
	import pcc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             func,
	input  wire logic [INDEX_W-1:0]     entry_index,
	input  wire logic [COMP_W-1:0]      entry_red,
	input  wire logic [COMP_W-1:0]      entry_green,
	input  wire logic [COMP_W-1:0]      entry_blue,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [COMP_W-1:0]      color_red,
	output logic      [COMP_W-1:0]      color_green,
	output logic      [COMP_W-1:0]      color_blue,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW          = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W       = $clog2(OUTQ_DEPTH + 1);
	localparam int PROD_W      = COMP_W + WEIGHT_W + 2;
	localparam int BLEND_SHIFT = 8;
	localparam logic signed [PROD_W-1:0] COMP_MAX = PROD_W'((1 << COMP_W) - 1);

	function automatic logic [INDEX_W-1:0] wrap_addr(
		input logic [INDEX_W-1:0] pos,
		input logic [INDEX_W-1:0] off,
		input logic [SIZE_W-1:0]  size,
		input logic [INDEX_W-1:0] first
	);
		logic [SIZE_W-1:0] sum;
		sum = {1'b0, pos} + {1'b0, off};
		if (sum >= size) begin
			sum = sum - size;
		end
		return first + sum[INDEX_W-1:0];
	endfunction

	function automatic logic signed [PROD_W-1:0] blend_prod(
		input logic [COMP_W-1:0]   a,
		input logic [COMP_W-1:0]   b,
		input logic [WEIGHT_W-1:0] w
	);
		logic signed [COMP_W:0]   d;
		logic signed [WEIGHT_W:0] ws;
		logic signed [PROD_W-1:0] dx;
		logic signed [PROD_W-1:0] wx;
		d  = $signed({1'b0, b}) - $signed({1'b0, a});
		ws = $signed({1'b0, w});
		dx = PROD_W'(d);
		wx = PROD_W'(ws);
		return dx * wx;
	endfunction

	function automatic logic [COMP_W-1:0] blend_sum(
		input logic [COMP_W-1:0]          a,
		input logic signed [PROD_W-1:0]   p
	);
		logic signed [PROD_W-1:0] q;
		logic signed [PROD_W-1:0] v;
		q = p >>> BLEND_SHIFT;
		v = $signed(PROD_W'({1'b0, a})) + q;
		if (v < 0) begin
			return '0;
		end else if (v > COMP_MAX) begin
			return COMP_MAX[COMP_W-1:0];
		end
		return v[COMP_W-1:0];
	endfunction

	range_t rng;
	rot_t   rot;
	func_t  fn;
	logic   in_acc;
	logic   read_acc;
	logic   pop;
	logic   in_rng;
	logic [CNT_W-1:0] pending_q;

	logic                valid_s1;
	logic                write_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [INDEX_W-1:0]  pos_s1;
	logic                in_range_s1;
	logic [INDEX_W-1:0]  off1_s1;
	logic [INDEX_W-1:0]  off2_s1;
	logic [WEIGHT_W-1:0] weight_s1;
	color_t              color_s1;

	logic [INDEX_W-1:0]  addr1;
	logic [INDEX_W-1:0]  addr2;
	logic                wr_en;
	logic                rd_en;
	color_t              rd_a;
	color_t              rd_b;

	logic                valid_s2;
	logic                hit1_s2;
	logic                hit2_s2;
	logic [WEIGHT_W-1:0] weight_s2;
	color_t              c1;
	color_t              c2;

	logic                     valid_s3;
	color_t                   base_s3;
	logic signed [PROD_W-1:0] prod_r_s3;
	logic signed [PROD_W-1:0] prod_g_s3;
	logic signed [PROD_W-1:0] prod_b_s3;
	color_t                   blended;
	color_t                   head;

	assign fn        = func_t'(func);
	assign cfg_ready = 1'b1;
	assign in_stall  = rot.busy || (pending_q == CNT_W'(OUTQ_DEPTH));
	assign in_acc    = in_valid && !in_stall;
	assign read_acc  = in_acc && (fn == FUNC_READ);
	assign pop       = out_valid && !out_stall;
	assign in_rng    = rng.ranged && (entry_index >= rng.first) && (entry_index <= rng.last);

	pcc_rot u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.tick     (in_acc && (fn == FUNC_TICK)),
		.rewind   (in_acc && (fn == FUNC_REWIND)),
		.rng      (rng),
		.rot      (rot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
		end else begin
			pending_q <= pending_q + CNT_W'(read_acc) - CNT_W'(pop);
			valid_s1  <= in_acc && ((fn == FUNC_LOAD) || (fn == FUNC_READ));
			valid_s2  <= rd_en;
			valid_s3  <= valid_s2;
		end
	end

	// capture the item with the offsets and weight in force when it was taken
	always_ff @(posedge clk) begin
		if (in_acc) begin
			write_s1    <= fn == FUNC_LOAD;
			index_s1    <= entry_index;
			pos_s1      <= entry_index - rng.first;
			in_range_s1 <= in_rng;
			off1_s1     <= rot.offset_now;
			off2_s1     <= rot.offset_next;
			weight_s1   <= (in_rng && rng.blend_en) ? rot.weight : '0;
			color_s1    <= '{red: entry_red, green: entry_green, blue: entry_blue};
		end
	end

	always_comb begin
		addr1 = in_range_s1 ? wrap_addr(pos_s1, off1_s1, rng.size, rng.first) : index_s1;
		addr2 = in_range_s1 ? wrap_addr(pos_s1, off2_s1, rng.size, rng.first) : index_s1;
		wr_en = valid_s1 && write_s1 && ({1'b0, index_s1} < SIZE_W'(PALETTE_ENTRIES));
		rd_en = valid_s1 && !write_s1;
	end

	pcc_ram #(
		.WIDTH($bits(color_t)),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (index_s1[AW-1:0]),
		.wr_data  (color_s1),
		.rd_en    (rd_en),
		.rd_addr_a(addr1[AW-1:0]),
		.rd_addr_b(addr2[AW-1:0]),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit1_s2   <= {1'b0, addr1} < SIZE_W'(PALETTE_ENTRIES);
			hit2_s2   <= {1'b0, addr2} < SIZE_W'(PALETTE_ENTRIES);
			weight_s2 <= weight_s1;
		end
	end

	assign c1 = hit1_s2 ? rd_a : '0;
	assign c2 = hit2_s2 ? rd_b : '0;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			base_s3   <= c1;
			prod_r_s3 <= blend_prod(c1.red, c2.red, weight_s2);
			prod_g_s3 <= blend_prod(c1.green, c2.green, weight_s2);
			prod_b_s3 <= blend_prod(c1.blue, c2.blue, weight_s2);
		end
	end

	always_comb begin
		blended.red   = blend_sum(base_s3.red, prod_r_s3);
		blended.green = blend_sum(base_s3.green, prod_g_s3);
		blended.blue  = blend_sum(base_s3.blue, prod_b_s3);
	end

	pcc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s3),
		.push_data(blended),
		.pop      (pop),
		.valid    (out_valid),
		.head     (head)
	);

	assign color_red   = head.red;
	assign color_green = head.green;
	assign color_blue  = head.blue;

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(OUTQ_DEPTH))
		else $error("more reads in flight than queue slots");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 || out_valid) |-> (pending_q != '0))
		else $error("result without an owed read");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the palette color cycler: random items, own color predictor.
module tb;
	import pcc_pkg::*;

	typedef struct packed {
		func_t              f;
		logic [INDEX_W-1:0] idx;
		color_t             c;
	} pal_item_t;

	typedef struct packed {
		cfg_reg_t              sel;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_LIMIT   = 100;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic [1:0]             func        = FUNC_LOAD;
	logic [INDEX_W-1:0]     entry_index = '0;
	logic [COMP_W-1:0]      entry_red   = '0;
	logic [COMP_W-1:0]      entry_green = '0;
	logic [COMP_W-1:0]      entry_blue  = '0;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic [COMP_W-1:0]      color_red;
	logic [COMP_W-1:0]      color_green;
	logic [COMP_W-1:0]      color_blue;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = REG_FIRST_INDEX;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	palette_color_cycler dut (.*);

	always #5 clk = ~clk;

	// predicted state of the block
	color_t             pal [256];
	logic [INDEX_W-1:0] rot_off   = '0;
	logic [INDEX_W-1:0] tick_cnt  = '0;
	logic [INDEX_W-1:0] reg_first = '0;
	logic [INDEX_W-1:0] reg_last  = '0;
	logic [INDEX_W-1:0] reg_delay = 8'd1;
	logic               rev_dir   = 1'b0;

	color_t     color_q [$];
	pal_item_t  item_q [$];
	pal_item_t  on_port;
	reg_write_t reg_q [$];
	reg_write_t reg_now;
	color_t     got;
	color_t     want;
	logic       feed_next;
	logic       cfg_next;
	int         items_queued = 0;
	int         items_taken  = 0;
	int         regs_issued  = 0;
	int         regs_done    = 0;
	int         burst_left   = 0;
	int         gap_left     = 0;
	int         hold_left    = 0;
	int         free_left    = 0;
	int         mismatches   = 0;
	int         cycles       = 0;

	task automatic flag(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic int unsigned next_offset(int unsigned cur, int unsigned span);
		int unsigned c;
		c = cur % span;
		if (rev_dir)
			return (c + span - 1) % span;
		return (c + 1) % span;
	endfunction

	function automatic logic [COMP_W-1:0] mix(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
			int unsigned w);
		int p;
		int v;
		p = (int'(b) - int'(a)) * int'(w);
		v = int'(a) + (p >>> 8);
		if (v < 0)
			v = 0;
		if (v > 63)
			v = 63;
		return COMP_W'(v);
	endfunction

	task automatic advance_model(pal_item_t it);
		int unsigned span;
		int unsigned pos;
		int unsigned o1;
		int unsigned o2;
		int unsigned w;
		int unsigned div;
		bit          ranged;
		color_t      c1;
		color_t      c2;
		color_t      res;
		ranged = reg_last >= reg_first;
		span = ranged ? int'(reg_last) - int'(reg_first) + 1 : 0;
		div = (reg_delay == 0) ? 1 : reg_delay;
		case (it.f)
		FUNC_LOAD: begin
			pal[it.idx] = it.c;
		end
		FUNC_TICK: begin
			if (tick_cnt + 1 < div) begin
				tick_cnt++;
			end else begin
				tick_cnt = '0;
				if (ranged)
					rot_off = INDEX_W'(next_offset(rot_off, span));
			end
		end
		FUNC_REWIND: begin
			rot_off = '0;
			tick_cnt = '0;
		end
		FUNC_READ: begin
			if (ranged && it.idx >= reg_first && it.idx <= reg_last) begin
				pos = it.idx - reg_first;
				o1 = rot_off % span;
				o2 = next_offset(rot_off, span);
				w = (span <= 2) ? 0 : (256 * tick_cnt) / div;
				c1 = pal[reg_first + (pos + o1) % span];
				c2 = pal[reg_first + (pos + o2) % span];
				res.red = mix(c1.red, c2.red, w);
				res.green = mix(c1.green, c2.green, w);
				res.blue = mix(c1.blue, c2.blue, w);
			end else begin
				res = pal[it.idx];
			end
			color_q.push_back(res);
		end
		endcase
	endtask

	// item driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			feed_next = in_valid;
			if (in_valid && !in_stall) begin
				advance_model(on_port);
				items_taken++;
				feed_next = 1'b0;
			end
			if (!feed_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (item_q.size() > 0) begin
					on_port = item_q.pop_front();
					func <= on_port.f;
					entry_index <= on_port.idx;
					entry_red <= on_port.c.red;
					entry_green <= on_port.c.green;
					entry_blue <= on_port.c.blue;
					feed_next = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= feed_next;
		end
	end

	// register writer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			cfg_next = cfg_valid;
			if (cfg_valid && cfg_ready) begin
				case (reg_now.sel)
				REG_FIRST_INDEX: begin
					reg_first = reg_now.data;
				end
				REG_LAST_INDEX: begin
					reg_last = reg_now.data;
				end
				REG_CYCLE_DELAY: begin
					reg_delay = reg_now.data;
				end
				REG_REVERSE_DIRECTION: begin
					rev_dir = reg_now.data[0];
				end
				endcase
				regs_done++;
				cfg_next = 1'b0;
			end
			if (!cfg_next && reg_q.size() > 0) begin
				reg_now = reg_q.pop_front();
				cfg_index <= reg_now.sel;
				cfg_data <= reg_now.data;
				cfg_next = 1'b1;
			end
			cfg_valid <= cfg_next;
		end
	end

	// color monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {color_red, color_green, color_blue};
				if (color_q.size() == 0) begin
					flag($sformatf("color %h with nothing pending", got));
				end else begin
					want = color_q.pop_front();
					if (got !== want)
						flag($sformatf("color r%0d g%0d b%0d, want r%0d g%0d b%0d",
							got.red, got.green, got.blue, want.red, want.green, want.blue));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				free_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 10);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic queue_item(func_t f, logic [INDEX_W-1:0] idx, color_t c);
		pal_item_t it;
		it.f = f;
		it.idx = idx;
		it.c = c;
		item_q.push_back(it);
		items_queued++;
	endtask

	// hold until every item is taken and every color is back, then let the block go idle
	task automatic settle();
		while (items_taken != items_queued || color_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [7:0] f, logic [7:0] l, logic [7:0] d, logic r);
		reg_q.push_back('{REG_FIRST_INDEX, f});
		reg_q.push_back('{REG_LAST_INDEX, l});
		reg_q.push_back('{REG_CYCLE_DELAY, d});
		reg_q.push_back('{REG_REVERSE_DIRECTION, {7'd0, r}});
		regs_issued += 4;
		while (regs_done != regs_issued)
			@(posedge clk);
	endtask

	task automatic run_phase(logic [7:0] f, logic [7:0] l, logic [7:0] d, logic r, int n);
		int    pick;
		int    k;
		func_t fn;
		logic [INDEX_W-1:0] idx;
		write_regs(f, l, d, r);
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			idx = 8'($urandom);
			if (k < 4 || pick < 50) begin
				fn = FUNC_READ;
				if (l >= f && $urandom_range(0, 3) != 0)
					idx = 8'($urandom_range(l, f));
			end else if (pick < 75) begin
				fn = FUNC_TICK;
			end else if (pick < 92) begin
				fn = FUNC_LOAD;
			end else begin
				fn = FUNC_REWIND;
			end
			queue_item(fn, idx, 18'($urandom));
		end
		settle();
	endtask

	initial begin
		int k;
		logic [7:0] rf;
		logic [7:0] rl;
		foreach (pal[k])
			pal[k] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole table so that no read touches an unloaded entry
		for (k = 0; k < 256; k++)
			queue_item(FUNC_LOAD, 8'(k), 18'($urandom));
		queue_item(FUNC_READ, 8'd0, 18'($urandom));
		queue_item(FUNC_READ, 8'd1, 18'($urandom));
		settle();

		write_regs(8'd4, 8'd11, 8'd4, 1'b0);
		queue_item(FUNC_READ, 8'd0, 18'($urandom));
		queue_item(FUNC_READ, 8'd255, 18'($urandom));
		queue_item(FUNC_READ, 8'd4, 18'($urandom));
		queue_item(FUNC_READ, 8'd11, 18'($urandom));
		queue_item(FUNC_TICK, 8'($urandom), 18'($urandom));
		queue_item(FUNC_READ, 8'd4, 18'($urandom));
		queue_item(FUNC_READ, 8'd11, 18'($urandom));
		repeat (3) queue_item(FUNC_TICK, 8'($urandom), 18'($urandom));
		queue_item(FUNC_READ, 8'd4, 18'($urandom));
		queue_item(FUNC_LOAD, 8'd4, 18'h3ffff);
		queue_item(FUNC_LOAD, 8'd5, 18'h00000);
		repeat (2) queue_item(FUNC_TICK, 8'($urandom), 18'($urandom));
		queue_item(FUNC_READ, 8'd4, 18'($urandom));
		queue_item(FUNC_READ, 8'd11, 18'($urandom));
		queue_item(FUNC_READ, 8'd3, 18'($urandom));
		queue_item(FUNC_REWIND, 8'($urandom), 18'($urandom));
		queue_item(FUNC_READ, 8'd4, 18'($urandom));
		queue_item(FUNC_LOAD, 8'd0, 18'h3ffff);
		queue_item(FUNC_LOAD, 8'd255, 18'h00000);
		queue_item(FUNC_READ, 8'd0, 18'($urandom));
		queue_item(FUNC_READ, 8'd255, 18'($urandom));
		settle();

		run_phase(8'd0, 8'd255, 8'd255, 1'b1, 100);
		// stale tick and offset from the slow full range
		run_phase(8'd50, 8'd65, 8'd3, 1'b0, 130);
		run_phase(8'd255, 8'd255, 8'd1, 1'b0, 70);
		run_phase(8'd20, 8'd0, 8'd7, 1'b1, 70);
		run_phase(8'd100, 8'd102, 8'd0, 1'b0, 90);
		run_phase(8'd30, 8'd31, 8'd3, 1'b1, 70);
		repeat (2) begin
			rf = 8'($urandom);
			rl = (rf > 8'd235) ? 8'd255 : rf + 8'($urandom_range(0, 20));
			run_phase(rf, rl, 8'($urandom_range(1, 6)), 1'($urandom), 130);
		end

		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
